// ===== design/lswc_pkg.sv =====
// Shared constants, codes and the outcode function of the line segment window clipper.
// Depends on nothing; lswc_clip_stage and the top unit import it, lswc_div_step does not.
`default_nettype none

package lswc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CLIP_STAGES     = 4;

  localparam logic [3:0] OC_TOP    = 4'b1000;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_INSIDE = 4'b0000;

  localparam int RST_WIN_LEFT   = -70;
  localparam int RST_WIN_BOTTOM = -50;
  localparam int RST_WIN_RIGHT  = 70;
  localparam int RST_WIN_TOP    = 50;

  typedef enum logic [1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_BOTTOM = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_TOP    = 2'd3
  } cfg_reg_t;

  // Coordinates arrive sign-extended to 32 bits.
  function automatic logic [3:0] outcode(
    input logic signed [31:0] x,
    input logic signed [31:0] y,
    input logic signed [31:0] left,
    input logic signed [31:0] bottom,
    input logic signed [31:0] right,
    input logic signed [31:0] top
  );
    logic [3:0] c;
    c = OC_INSIDE;
    if (y > top) begin
      c = OC_TOP;
    end else if (y < bottom) begin
      c = OC_BOTTOM;
    end
    if (x > right) begin
      c = c | OC_RIGHT;
    end else if (x < left) begin
      c = c | OC_LEFT;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/lswc_div_step.sv =====
// One restoring division step with its pipeline register; one quotient bit per stage.
// Depends on nothing.
`default_nettype none

module lswc_div_step #(
  parameter int DW = 17,
  parameter int QW = 16,
  parameter int SW = 100
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire logic [DW-1:0]   in_rem,
  input  wire logic [2*DW-1:0] in_dvd,
  input  wire logic [DW-1:0]   in_dsr,
  input  wire logic [QW-1:0]   in_quo,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_valid,
  output logic [DW-1:0]        out_rem,
  output logic [2*DW-1:0]      out_dvd,
  output logic [DW-1:0]        out_dsr,
  output logic [QW-1:0]        out_quo,
  output logic [SW-1:0]        out_side
);

  logic              valid_r;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [2*DW-1:0]   dvd_r;
  logic [DW-1:0]     dsr_r;
  logic [QW-1:0]     quo_r;
  logic [SW-1:0]     side_r;
  logic [DW:0]       rs;
  logic [DW:0]       diff;
  logic              ge;

  always_comb begin
    rs      = {in_rem, in_dvd[2*DW-1]};
    ge      = rs >= {1'b0, in_dsr};
    diff    = rs - {1'b0, in_dsr};
    // remainder stays below the divisor, so the top bit drops
    rem_nxt = ge ? diff[DW-1:0] : rs[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {in_dvd[2*DW-2:0], 1'b0};
      dsr_r  <= in_dsr;
      quo_r  <= {in_quo[QW-2:0], ge};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_dvd   = dvd_r;
  assign out_dsr   = dsr_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ===== design/lswc_clip_stage.sv =====
// One clip pass: outcode and edge pick, multiply, bit-serial pipelined divide, endpoint update.
// Depends on lswc_pkg and lswc_div_step.
`default_nettype none

module lswc_clip_stage #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic signed [COORD_WIDTH-1:0] win_left,
  input  wire logic signed [COORD_WIDTH-1:0] win_bottom,
  input  wire logic signed [COORD_WIDTH-1:0] win_right,
  input  wire logic signed [COORD_WIDTH-1:0] win_top,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] in_x1,
  input  wire logic signed [COORD_WIDTH-1:0] in_y1,
  input  wire logic signed [COORD_WIDTH-1:0] in_x2,
  input  wire logic signed [COORD_WIDTH-1:0] in_y2,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      out_x1,
  output logic signed [COORD_WIDTH-1:0]      out_y1,
  output logic signed [COORD_WIDTH-1:0]      out_x2,
  output logic signed [COORD_WIDTH-1:0]      out_y2
);
  import lswc_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;
  localparam int NSTEP = 2 * DW;
  localparam int SW    = 6 * W + 4;

  // ---------------- setup ----------------
  logic [3:0]          c1, c2, cm;
  logic                act, first, yaxis, zero, neg;
  logic signed [W-1:0] px, py, qx, qy, a1, a2, o1, o2, edge_v;
  logic signed [DW-1:0] da, dn, dt;
  logic [DW-1:0]       m_da, m_dn, m_t;

  always_comb begin
    c1    = outcode(32'(in_x1), 32'(in_y1), 32'(win_left), 32'(win_bottom),
                    32'(win_right), 32'(win_top));
    c2    = outcode(32'(in_x2), 32'(in_y2), 32'(win_left), 32'(win_bottom),
                    32'(win_right), 32'(win_top));
    act   = ((c1 | c2) != OC_INSIDE) && ((c1 & c2) == OC_INSIDE);
    first = c1 != OC_INSIDE;
    cm    = first ? c1 : c2;
    px    = first ? in_x1 : in_x2;
    py    = first ? in_y1 : in_y2;
    qx    = first ? in_x2 : in_x1;
    qy    = first ? in_y2 : in_y1;
    yaxis = ((cm & (OC_TOP | OC_BOTTOM)) != OC_INSIDE);
    priority if ((cm & OC_TOP) != OC_INSIDE) begin
      edge_v = win_top;
    end else if ((cm & OC_BOTTOM) != OC_INSIDE) begin
      edge_v = win_bottom;
    end else if ((cm & OC_RIGHT) != OC_INSIDE) begin
      edge_v = win_right;
    end else begin
      edge_v = win_left;
    end
    a1   = yaxis ? py : px;
    o1   = yaxis ? px : py;
    a2   = yaxis ? qy : qx;
    o2   = yaxis ? qx : qy;
    da   = DW'(a2) - DW'(a1);
    dn   = DW'(o2) - DW'(o1);
    dt   = DW'(edge_v) - DW'(a1);
    zero = (da == '0) || (dn == '0) || (dt == '0);
    neg  = da[DW-1] ^ dn[DW-1] ^ dt[DW-1];
    m_da = da[DW-1] ? DW'(~da + 1'b1) : DW'(da);
    m_dn = dn[DW-1] ? DW'(~dn + 1'b1) : DW'(dn);
    m_t  = dt[DW-1] ? DW'(~dt + 1'b1) : DW'(dt);
  end

  logic              s1_valid_r;
  logic [SW-1:0]     s1_side_r;
  logic [DW-1:0]     s1_mdn_r, s1_mt_r, s1_dsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  // a zero delta or distance gives an offset of zero: force 0 / 1
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= {in_x1, in_y1, in_x2, in_y2, edge_v, o1, act, first, yaxis, neg};
      s1_mdn_r  <= zero ? '0 : m_dn;
      s1_mt_r   <= m_t;
      s1_dsr_r  <= zero ? DW'(1) : m_da;
    end
  end

  // ---------------- multiply ----------------
  logic              s2_valid_r;
  logic [SW-1:0]     s2_side_r;
  logic [2*DW-1:0]   s2_prod_r;
  logic [DW-1:0]     s2_dsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= s1_side_r;
      s2_prod_r <= s1_mdn_r * s1_mt_r;
      s2_dsr_r  <= s1_dsr_r;
    end
  end

  // ---------------- divide ----------------
  logic              d_valid [0:NSTEP];
  logic [DW-1:0]     d_rem   [0:NSTEP];
  logic [2*DW-1:0]   d_dvd   [0:NSTEP];
  logic [DW-1:0]     d_dsr   [0:NSTEP];
  logic [W-1:0]      d_quo   [0:NSTEP];
  logic [SW-1:0]     d_side  [0:NSTEP];

  assign d_valid[0] = s2_valid_r;
  assign d_rem[0]   = '0;
  assign d_dvd[0]   = s2_prod_r;
  assign d_dsr[0]   = s2_dsr_r;
  assign d_quo[0]   = '0;
  assign d_side[0]  = s2_side_r;

  for (genvar i = 0; i < NSTEP; i++) begin : g_div
    lswc_div_step #(
      .DW (DW),
      .QW (W),
      .SW (SW)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (d_valid[i]),
      .in_rem    (d_rem[i]),
      .in_dvd    (d_dvd[i]),
      .in_dsr    (d_dsr[i]),
      .in_quo    (d_quo[i]),
      .in_side   (d_side[i]),
      .out_valid (d_valid[i+1]),
      .out_rem   (d_rem[i+1]),
      .out_dvd   (d_dvd[i+1]),
      .out_dsr   (d_dsr[i+1]),
      .out_quo   (d_quo[i+1]),
      .out_side  (d_side[i+1])
    );
  end

  // ---------------- update ----------------
  logic signed [W-1:0] u_x1, u_y1, u_x2, u_y2, u_edge, u_o1;
  logic                u_act, u_first, u_yaxis, u_neg;
  logic [W-1:0]        nc;
  logic signed [W-1:0] nx, ny;
  logic signed [W-1:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt;

  assign {u_x1, u_y1, u_x2, u_y2, u_edge, u_o1, u_act, u_first, u_yaxis, u_neg} =
    d_side[NSTEP];

  always_comb begin
    nc     = u_neg ? (W'(u_o1) - d_quo[NSTEP]) : (W'(u_o1) + d_quo[NSTEP]);
    nx     = u_yaxis ? $signed(nc) : u_edge;
    ny     = u_yaxis ? u_edge : $signed(nc);
    x1_nxt = u_x1;
    y1_nxt = u_y1;
    x2_nxt = u_x2;
    y2_nxt = u_y2;
    if (u_act && u_first) begin
      x1_nxt = nx;
      y1_nxt = ny;
    end else if (u_act) begin
      x2_nxt = nx;
      y2_nxt = ny;
    end
  end

  logic                valid_r;
  logic signed [W-1:0] x1_r, y1_r, x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= d_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r <= x1_nxt;
      y1_r <= y1_nxt;
      x2_r <= x2_nxt;
      y2_r <= y2_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x1    = x1_r;
  assign out_y1    = y1_r;
  assign out_x2    = x2_r;
  assign out_y2    = y2_r;

endmodule

`default_nettype wire

// ===== design/line_segment_window_clipper_unit.sv =====
// Cohen-Sutherland line clipper: window registers, four clip passes, result register.
// Depends on lswc_pkg and lswc_clip_stage.
//
// Usage:
//   Input channel in_*: one segment (start and end point) per request, taken when
//   in_valid is high and in_stall is low. Output channel out_*: out_accepted and the
//   clipped endpoints; endpoints read zero for a rejected segment.
//   Configuration: cfg_wen writes cfg_wdata into the window register picked by
//   cfg_index (left, bottom, right, top). Write only while no request is in flight.
//   Pipeline: each
//   clip pass has a setup stage, a multiply stage, 2 * (COORD_WIDTH + 1) divide
//   stages (one quotient bit each) and an update stage; one result stage follows.
//   Throughput: one request per cycle while in_stall is low.
//   Reset: valid bits clear, the window returns to left -70, bottom -50,
//   right 70, top 50.
//   Stall: while out_valid is high and out_stall is high the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated.
`default_nettype none

module line_segment_window_clipper_unit #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_accepted,
  output logic signed [COORD_WIDTH-1:0]      out_clip_start_x,
  output logic signed [COORD_WIDTH-1:0]      out_clip_start_y,
  output logic signed [COORD_WIDTH-1:0]      out_clip_end_x,
  output logic signed [COORD_WIDTH-1:0]      out_clip_end_y,
  input  wire logic                          cfg_wen,
  input  wire lswc_pkg::cfg_reg_t            cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_wdata
);
  import lswc_pkg::*;

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= W'(RST_WIN_LEFT);
      win_bottom_r <= W'(RST_WIN_BOTTOM);
      win_right_r  <= W'(RST_WIN_RIGHT);
      win_top_r    <= W'(RST_WIN_TOP);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_WIN_LEFT:   win_left_r   <= $signed(cfg_wdata);
        REG_WIN_BOTTOM: win_bottom_r <= $signed(cfg_wdata);
        REG_WIN_RIGHT:  win_right_r  <= $signed(cfg_wdata);
        REG_WIN_TOP:    win_top_r    <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic adv;

  // advance everything unless the result waits on a stalled receiver
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic                st_valid [0:CLIP_STAGES];
  logic signed [W-1:0] st_x1    [0:CLIP_STAGES];
  logic signed [W-1:0] st_y1    [0:CLIP_STAGES];
  logic signed [W-1:0] st_x2    [0:CLIP_STAGES];
  logic signed [W-1:0] st_y2    [0:CLIP_STAGES];

  assign st_valid[0] = in_valid;
  assign st_x1[0]    = in_start_x;
  assign st_y1[0]    = in_start_y;
  assign st_x2[0]    = in_end_x;
  assign st_y2[0]    = in_end_y;

  for (genvar s = 0; s < CLIP_STAGES; s++) begin : g_clip
    lswc_clip_stage #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_clip (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .win_left   (win_left_r),
      .win_bottom (win_bottom_r),
      .win_right  (win_right_r),
      .win_top    (win_top_r),
      .in_valid   (st_valid[s]),
      .in_x1      (st_x1[s]),
      .in_y1      (st_y1[s]),
      .in_x2      (st_x2[s]),
      .in_y2      (st_y2[s]),
      .out_valid  (st_valid[s+1]),
      .out_x1     (st_x1[s+1]),
      .out_y1     (st_y1[s+1]),
      .out_x2     (st_x2[s+1]),
      .out_y2     (st_y2[s+1])
    );
  end

  logic [3:0] fc1, fc2;
  logic       acc;

  always_comb begin
    fc1 = outcode(32'(st_x1[CLIP_STAGES]), 32'(st_y1[CLIP_STAGES]), 32'(win_left_r),
                  32'(win_bottom_r), 32'(win_right_r), 32'(win_top_r));
    fc2 = outcode(32'(st_x2[CLIP_STAGES]), 32'(st_y2[CLIP_STAGES]), 32'(win_left_r),
                  32'(win_bottom_r), 32'(win_right_r), 32'(win_top_r));
    acc = (fc1 | fc2) == OC_INSIDE;
  end

  logic                acc_r;
  logic signed [W-1:0] ox1_r, oy1_r, ox2_r, oy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_valid[CLIP_STAGES];
    end
  end

  // zero the endpoints of a rejected segment
  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc;
      ox1_r <= acc ? st_x1[CLIP_STAGES] : '0;
      oy1_r <= acc ? st_y1[CLIP_STAGES] : '0;
      ox2_r <= acc ? st_x2[CLIP_STAGES] : '0;
      oy2_r <= acc ? st_y2[CLIP_STAGES] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = acc_r;
  assign out_clip_start_x = ox1_r;
  assign out_clip_start_y = oy1_r;
  assign out_clip_end_x   = ox2_r;
  assign out_clip_end_y   = oy2_r;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for line_segment_window_clipper_unit: Cohen-Sutherland clipping.
// Predicts each clipped segment in place and compares in order; needs lswc_pkg and the unit.
`timescale 1ns / 100ps

module tb_top;
  import lswc_pkg::*;

  localparam int CW = 16;
  localparam int PIPE_LAT = 4 * (2 * CW + 5) + 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    logic   acc;
    coord_t sx, sy, ex, ey;
  } clip_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  coord_t out_clip_start_x, out_clip_start_y, out_clip_end_x, out_clip_end_y;
  logic cfg_wen = 1'b0;
  cfg_reg_t cfg_index = REG_WIN_LEFT;
  logic [CW-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  line_segment_window_clipper_unit #(.COORD_WIDTH(CW)) i_dut (.*);

  // window as the predictor sees it
  longint wl = RST_WIN_LEFT, wb = RST_WIN_BOTTOM, wr = RST_WIN_RIGHT, wt = RST_WIN_TOP;
  clip_res_t clip_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;

  function automatic logic [3:0] region(longint x, longint y);
    logic [3:0] c;
    c = OC_INSIDE;
    if (y > wt) c = OC_TOP;
    else if (y < wb) c = OC_BOTTOM;
    if (x > wr) c |= OC_RIGHT;
    else if (x < wl) c |= OC_LEFT;
    return c;
  endfunction

  function automatic longint wrap16(longint v);
    logic [CW-1:0] b;
    b = v[CW-1:0];
    return longint'($signed(b));
  endfunction

  // other coordinate where the clip axis reaches edge; offset truncated toward zero
  function automatic longint edge_cross(longint a1, longint o1, longint a2, longint o2,
                                        longint edge_v);
    longint da, dn, t, q;
    da = a2 - a1;
    dn = o2 - o1;
    t = edge_v - a1;
    if (da == 0 || dn == 0 || t == 0) return o1;
    q = (dn * t) / da;
    return wrap16(o1 + q);
  endfunction

  function automatic clip_res_t clip_segment(coord_t ix1, coord_t iy1, coord_t ix2, coord_t iy2);
    longint x1, y1, x2, y2, nx, ny;
    logic [3:0] c1, c2, c;
    logic first;
    clip_res_t r;
    x1 = ix1; y1 = iy1; x2 = ix2; y2 = iy2;
    c1 = region(x1, y1);
    c2 = region(x2, y2);
    for (int s = 0; s < CLIP_STAGES; s++) begin
      if ((c1 | c2) == 0 || (c1 & c2) != 0) break;
      first = (c1 != 0);
      c = first ? c1 : c2;
      if (c & (OC_TOP | OC_BOTTOM)) begin
        ny = (c & OC_TOP) ? wt : wb;
        nx = first ? edge_cross(y1, x1, y2, x2, ny) : edge_cross(y2, x2, y1, x1, ny);
      end else begin
        nx = (c & OC_RIGHT) ? wr : wl;
        ny = first ? edge_cross(x1, y1, x2, y2, nx) : edge_cross(x2, y2, x1, y1, nx);
      end
      if (first) begin
        x1 = nx; y1 = ny; c1 = region(x1, y1);
      end else begin
        x2 = nx; y2 = ny; c2 = region(x2, y2);
      end
    end
    r.acc = ((c1 | c2) == 0);
    r.sx = r.acc ? coord_t'(x1) : '0;
    r.sy = r.acc ? coord_t'(y1) : '0;
    r.ex = r.acc ? coord_t'(x2) : '0;
    r.ey = r.acc ? coord_t'(y2) : '0;
    return r;
  endfunction

  // receiver: random stalls, plus a long hold when hold_cycles is set
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    clip_res_t exp_r, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_accepted, out_clip_start_x, out_clip_start_y, out_clip_end_x,
              out_clip_end_y};
      if (clip_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = clip_q.pop_front();
        if (got.acc !== exp_r.acc) begin
          $display("%0t: accepted expected %b actual %b", $time, exp_r.acc, got.acc);
          errors++;
        end
        if (got.sx !== exp_r.sx) begin
          $display("%0t: start_x expected %0d actual %0d", $time, exp_r.sx, got.sx);
          errors++;
        end
        if (got.sy !== exp_r.sy) begin
          $display("%0t: start_y expected %0d actual %0d", $time, exp_r.sy, got.sy);
          errors++;
        end
        if (got.ex !== exp_r.ex) begin
          $display("%0t: end_x expected %0d actual %0d", $time, exp_r.ex, got.ex);
          errors++;
        end
        if (got.ey !== exp_r.ey) begin
          $display("%0t: end_y expected %0d actual %0d", $time, exp_r.ey, got.ey);
          errors++;
        end
      end
    end
  end

  // send one request; valid stays high across back-to-back requests
  task automatic send_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= x1; in_start_y <= y1; in_end_x <= x2; in_end_y <= y2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_q.push_back(clip_segment(x1, y1, x2, y2));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (clip_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  task automatic write_window(cfg_reg_t idx, longint v);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[CW-1:0];
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_WIN_LEFT:   wl = wrap16(v);
      REG_WIN_BOTTOM: wb = wrap16(v);
      REG_WIN_RIGHT:  wr = wrap16(v);
      default:        wt = wrap16(v);
    endcase
  endtask

  task automatic set_window(longint l, longint b, longint r, longint t);
    drain();
    write_window(REG_WIN_LEFT, l);
    write_window(REG_WIN_BOTTOM, b);
    write_window(REG_WIN_RIGHT, r);
    write_window(REG_WIN_TOP, t);
  endtask

  function automatic coord_t near_window(logic horiz);
    longint lo, hi;
    lo = horiz ? wl : wb;
    hi = horiz ? wr : wt;
    if (lo > hi) begin
      longint tmp;
      tmp = lo; lo = hi; hi = tmp;
    end
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'(lo + $urandom_range(2) - 1);
      2: return coord_t'(hi + $urandom_range(2) - 1);
      default: return coord_t'(lo - 40 + $urandom_range(80) +
                               longint'($urandom_range(1000)) * (hi - lo + 80) / 1000);
    endcase
  endfunction

  task automatic test_directed();
    coord_t mx, mn;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    send_segment(0, 0, 10, 10);            // fully inside
    send_segment(-100, 60, 100, 70);       // trivially rejected above
    send_segment(-100, 0, 100, 0);         // crosses left and right
    send_segment(0, -100, 0, 100);         // crosses bottom and top
    send_segment(-200, -200, 200, 200);    // corner to corner
    send_segment(30, 100, 100, 30);        // passes just outside the top right corner
    send_segment(90, 80, -120, -60);       // both ends outside, crosses
    send_segment(70, 50, -70, -50);        // exactly on corners
    send_segment(mn, mn, mx, mx);
    send_segment(mx, mn, mn, mx);
    send_segment(mn, 0, mx, 0);
    send_segment(0, mx, 0, mn);
    send_segment(mx, mx, mx, mx);
    send_segment(60, 10, 200, 90);         // end point moved only
    send_segment(-80, 55, -60, 45);        // touches the top left corner
    set_window(-32768, -32768, 32767, 32767);
    send_segment(mn, mn, mx, mx);
    send_segment(1234, -4321, mx, mn);
    set_window(0, 0, 0, 0);                // single-point window
    send_segment(-5, -5, 5, 5);
    send_segment(-7, 3, 9, -2);
    set_window(50, 40, -50, -40);          // inverted window
    send_segment(-100, 0, 100, 0);
    send_segment(mn, mx, mx, mn);
    send_segment(3, -80, 3, 80);
    send_segment(0, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 120 == 0) begin
        case ($urandom_range(5))
          0: set_window(-70, -50, 70, 50);
          1: set_window(-32768, -32768, 32767, 32767);
          2: set_window(32767, 32767, -32768, -32768);
          3: set_window($signed(16'($urandom)), $signed(16'($urandom)),
                        $signed(16'($urandom)), $signed(16'($urandom)));
          default: begin
            longint a, b;
            a = longint'($urandom_range(60000)) - 30000;
            b = longint'($urandom_range(60000)) - 30000;
            set_window(a, b, a + $urandom_range(2000), b + $urandom_range(2000));
          end
        endcase
      end
      send_segment(near_window(1), near_window(0), near_window(1), near_window(0));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 200; i++)
      send_segment(near_window(1), near_window(0), near_window(1), near_window(0));
    drain();
    for (int i = 0; i < 20; i++)
      send_segment(near_window(1), near_window(0), near_window(1), near_window(0));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    send_idle = 7; recv_idle = 87;
    test_random(450);
    send_idle = 87; recv_idle = 7;
    test_random(450);
    send_idle = 0; recv_idle = 0;
    test_random(600);
    test_backpressure();
    drain();
    if (errors == 0 && clip_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #60ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
